### hdl/jsu_pkg.sv
// Package for the JSON string unescaper: decoder state and result types,
// character codes and the hex digit decode function. No dependencies.

package jsu_pkg;

	localparam int unsigned MAX_RESULTS = 5;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;
	localparam logic [5:0]  UTF8_MASK  = 6'h3F;
	localparam logic [15:0] CP_2BYTE   = 16'h0080;
	localparam logic [15:0] CP_3BYTE   = 16'h0800;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_HEX  = 3'b100
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  cnt;    // hex digits held, 0..3
		logic [11:0] cp;     // value of the held digits
	} dec_state_t;

	typedef struct packed {
		logic [4:0][7:0] bytes;  // entry 0 goes out first
		logic [2:0]      cnt;    // number of valid entries, 0..5
		logic            last;   // marks the final entry
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.value = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.value = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.value = 4'(b - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

### hdl/jsu_step.sv
// Escape decoder: holds the decode state and held hex digits, and turns one
// registered input byte into up to five result bytes. Uses jsu_pkg.

module jsu_step import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,       // item leaves the input stage this cycle
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output res_t       res
);

	dec_state_t st_q;
	dec_state_t nxt;
	logic [7:0] held_q [3];
	logic       held_we;
	hex_t       hx;
	logic [2:0] tail;
	logic [15:0] cp16;

	always_comb begin
		hx      = hex_decode(byte_in);
		cp16    = {st_q.cp, hx.value};
		tail    = 3'({1'b0, st_q.cnt}) + 3'd1;
		nxt     = st_q;
		held_we = 1'b0;
		res     = '0;
		res.last = last_in;
		unique case (st_q.mode)
			MODE_ESC: begin
				nxt.mode = MODE_TEXT;
				if (byte_in == CH_U && !last_in) begin
					nxt.mode = MODE_HEX;
					nxt.cnt  = 2'd0;
					nxt.cp   = '0;
				end else begin
					unique case (byte_in)
						CH_N:    res.bytes[0] = CH_LF;
						CH_T:    res.bytes[0] = CH_TAB;
						CH_R:    res.bytes[0] = CH_CR;
						default: res.bytes[0] = byte_in;
					endcase
					res.cnt = 3'd1;
				end
			end
			MODE_HEX: begin
				// flush layout: 'u', held digits, then the current byte unless it is a backslash that opens a new escape
				if (!hx.valid || (last_in && st_q.cnt != 2'd3)) begin
					res.bytes[0] = CH_U;
					res.bytes[1] = held_q[0];
					res.bytes[2] = held_q[1];
					res.bytes[3] = held_q[2];
					nxt.cnt  = 2'd0;
					nxt.cp   = '0;
					nxt.mode = MODE_TEXT;
					if (!hx.valid && byte_in == CH_BSLASH && !last_in) begin
						nxt.mode = MODE_ESC;
						res.cnt  = tail;
					end else begin
						res.bytes[tail] = byte_in;
						res.cnt         = tail + 3'd1;
					end
				end else if (st_q.cnt == 2'd3) begin
					if (cp16 < CP_2BYTE) begin
						res.bytes[0] = cp16[7:0];
						res.cnt      = 3'd1;
					end else if (cp16 < CP_3BYTE) begin
						res.bytes[0] = UTF8_LEAD2 | {3'b000, cp16[10:6]};
						res.bytes[1] = UTF8_CONT | {2'b00, cp16[5:0] & UTF8_MASK};
						res.cnt      = 3'd2;
					end else begin
						res.bytes[0] = UTF8_LEAD3 | {4'h0, cp16[15:12]};
						res.bytes[1] = UTF8_CONT | {2'b00, cp16[11:6] & UTF8_MASK};
						res.bytes[2] = UTF8_CONT | {2'b00, cp16[5:0] & UTF8_MASK};
						res.cnt      = 3'd3;
					end
					nxt.mode = MODE_TEXT;
					nxt.cnt  = 2'd0;
					nxt.cp   = '0;
				end else begin
					held_we = 1'b1;
					nxt.cp  = {st_q.cp[7:0], hx.value};
					nxt.cnt = st_q.cnt + 2'd1;
				end
			end
			default: begin
				if (byte_in == CH_BSLASH && !last_in) begin
					nxt.mode = MODE_ESC;
				end else begin
					nxt.mode     = MODE_TEXT;
					res.bytes[0] = byte_in;
					res.cnt      = 3'd1;
				end
			end
		endcase
		// a string end always drops back to plain text
		if (last_in) begin
			nxt.mode = MODE_TEXT;
			nxt.cnt  = 2'd0;
			nxt.cp   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= MODE_TEXT;
			st_q.cnt  <= 2'd0;
			st_q.cp   <= '0;
		end else if (adv) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && held_we) begin
			held_q[st_q.cnt] <= byte_in;
		end
	end

endmodule

### hdl/jsu_obuf.sv
// Result register: holds the bytes of one item and shifts them out one
// transfer at a time. Uses jsu_pkg.

module jsu_obuf import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	output logic       free,      // can take a new result this cycle
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast    // out_last
);

	logic [4:0][7:0] buf_q;
	logic [2:0]      rem_q;
	logic            last_q;
	logic            pop;

	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = buf_q[0];
	assign m_tlast  = last_q && (rem_q == 3'd1);
	assign pop      = m_tvalid && m_tready;
	assign free     = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= res.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= res.bytes;
			last_q <= res.last;
		end else if (pop) begin
			// advance to the next byte
			buf_q <= {8'h00, buf_q[4:1]};
		end
	end

endmodule

### hdl/json_string_unescape_utf8.sv
// JSON string content unescaper with UTF-8 output for \uXXXX escapes.
//
// Input stream (s_*): one raw content byte per transfer in s_tdata, s_tlast
// on the final byte of the string. Output stream (m_*): decoded bytes, one per
// transfer, m_tlast on the final decoded byte of the string.
// An input byte yields zero to five output bytes: none for a backslash or a
// held hex digit, one to three for a finished escape, up to five when a bad
// digit or an early string end flushes a partial \u escape.
// Each input byte is captured in the input register, decoded combinationally
// and its result bytes loaded into the result register, which presents them.
// Throughput: one input byte per cycle while each byte yields at most one
// output byte and m_tready stays high; the output side moves one byte per
// cycle when m_tready is high; the next item waits until the result drains.
// The input register takes a new byte while the result register drains its
// final byte, so no bubble appears between items.
// Reset clears the decoder to plain text and empties both registers.
// When the receiver stalls, the result register holds its byte and the input
// side stops after one more byte is held in the input register.
// Uses jsu_pkg, jsu_step, jsu_obuf.

module json_string_unescape_utf8 import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast    // out_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       obuf_free;
	logic       adv;
	logic       load;
	res_t       res;

	assign adv      = valid_s1 && obuf_free;
	assign load     = adv && (res.cnt != 3'd0);
	assign s_tready = !valid_s1 || obuf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	jsu_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	jsu_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.free     (obuf_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_obuf.rem_q <= 3'(MAX_RESULTS))
		else $error("result count above maximum");

	a_cnt_hex_only: assert property (@(posedge clk) disable iff (!arst_n)
		(u_step.st_q.mode != MODE_HEX) |-> (u_step.st_q.cnt == 2'd0))
		else $error("hex digits held outside a unicode escape");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded result not presented");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (u_step.st_q.mode == MODE_TEXT))
		else $error("decoder not back in text after string end");

endmodule
